// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define RHV_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define RHV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RHV_ASSERT(lbl, cond, msg)
`define RHV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/rhv_pkg.sv =====
// ----------------------------------------------------------------------------
// rhv_pkg
// Types and constants of the ROM header validator
// ----------------------------------------------------------------------------
`default_nettype none

package rhv_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int NAME_W  = 8;
    localparam int DESC_W  = 16;
    localparam int SIZE_W  = 32;
    localparam int MAGIC_W = 32;
    localparam int CFG_W   = 32;

    // fixed byte positions in the header
    localparam int POS_MAGIC_LAST = 3;
    localparam int POS_NAME_LEN   = 4;
    localparam int POS_DESC_LO    = 5;
    localparam int POS_DESC_HI    = 6;
    localparam int POS_SIZE_FIRST = 7;
    localparam int POS_SIZE_LAST  = 10;
    localparam int POS_CHECKSUM   = 11;
    localparam int FIXED_HDR_LEN  = 12;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAGIC_WORD = 1'b0,
        CFG_SIZE_LIMIT = 1'b1
    } rhv_cfg_idx_t;

    localparam logic [CFG_W-1:0] SIZE_LIMIT_RST = 32'd65536;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MAGIC  = 2'd1,
        ST_SIZE_LARGE = 2'd2,
        ST_CHK_FAIL   = 2'd3
    } rhv_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rhv_if.sv =====
// ----------------------------------------------------------------------------
// rhv_if
// Valid/ready channels of the ROM header validator: header bytes in, results out
// ----------------------------------------------------------------------------
`default_nettype none

interface rhv_in_if;
    logic                      valid;
    logic                      ready;
    logic [rhv_pkg::BYTE_W-1:0] data_byte;
    logic                      first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface rhv_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [rhv_pkg::NAME_W-1:0] name_length;
    logic [rhv_pkg::DESC_W-1:0] description_length;
    logic [rhv_pkg::SIZE_W-1:0] rom_size;

    modport source (output valid, output status, output name_length,
                    output description_length, output rom_size, input ready);
    modport sink   (input valid, input status, input name_length,
                    input description_length, input rom_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rom_header_validator_top.sv =====
// ----------------------------------------------------------------------------
// rom_header_validator_top
// Checks a byte-serial ROM header: magic, size limit and XOR checksum
// ----------------------------------------------------------------------------
// The block takes one header byte per clock cycle, back to back, and an
// accepted byte's result is in the output register in the next cycle. Each byte
// goes through a single registered update of the byte counter, the field
// captures and the running XOR, so the rate is one item per cycle; the input
// only stalls while a finished result sits in the output register and the
// sink is not taking it. A result appears on the first failure (bad magic at
// byte 3, size above the size limit register at byte 10) or after the last
// description byte; bytes after a result are dropped until the next first_byte
// flag. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module rom_header_validator_top #(
    parameter int UNUSED_BYTES = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [rhv_pkg::CFG_W-1:0]     cfg_data,
    rhv_in_if.sink                             in_ch,
    rhv_out_if.source                          out_ch
);

    // counter wide enough for the longest possible header
    localparam int MAX_LAST = rhv_pkg::FIXED_HDR_LEN + UNUSED_BYTES
                              + (2 ** rhv_pkg::NAME_W - 1) + (2 ** rhv_pkg::DESC_W - 1);
    localparam int POS_W = $clog2(MAX_LAST + 1);
    localparam int FIXED_LEN = rhv_pkg::FIXED_HDR_LEN + UNUSED_BYTES;

    // configuration registers
    logic [rhv_pkg::MAGIC_W-1:0] magic_word_reg;
    logic [rhv_pkg::SIZE_W-1:0]  max_size_reg;

    // header state
    logic                         active_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [23:0]                  magic_reg;
    logic [rhv_pkg::NAME_W-1:0]   name_reg;
    logic [rhv_pkg::DESC_W-1:0]   desc_reg;
    logic [rhv_pkg::SIZE_W-1:0]   size_reg;
    logic [rhv_pkg::BYTE_W-1:0]   chk_reg;
    logic [rhv_pkg::BYTE_W-1:0]   xor_reg;

    // result register
    logic                         out_valid_reg;
    rhv_pkg::rhv_status_t         status_reg;
    logic [rhv_pkg::NAME_W-1:0]   out_name_reg;
    logic [rhv_pkg::DESC_W-1:0]   out_desc_reg;
    logic [rhv_pkg::SIZE_W-1:0]   out_size_reg;

    // effective and next values for the byte in hand
    logic                         in_ready;
    logic                         accept;
    logic                         act;
    logic [rhv_pkg::BYTE_W-1:0]   b;
    logic [POS_W-1:0]             p;
    logic [23:0]                  magic_e;
    logic [rhv_pkg::NAME_W-1:0]   name_e;
    logic [rhv_pkg::DESC_W-1:0]   desc_e;
    logic [rhv_pkg::SIZE_W-1:0]   size_e;
    logic [rhv_pkg::BYTE_W-1:0]   chk_e;
    logic [rhv_pkg::BYTE_W-1:0]   xor_e;
    logic [23:0]                  magic_next;
    logic [rhv_pkg::NAME_W-1:0]   name_next;
    logic [rhv_pkg::DESC_W-1:0]   desc_next;
    logic [rhv_pkg::SIZE_W-1:0]   size_next;
    logic [rhv_pkg::BYTE_W-1:0]   chk_next;
    logic [rhv_pkg::BYTE_W-1:0]   xor_next;
    logic [1:0]                   size_sel;
    logic [POS_W-1:0]             last_pos;
    logic                         bad_magic;
    logic                         size_large;
    logic                         hdr_end;
    logic                         res_now;
    rhv_pkg::rhv_status_t         res_status;

    // handshake: a waiting result only blocks input when the sink stalls
    assign in_ready = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    // a first flag starts from a cleared header
    assign act     = in_ch.first_byte || active_reg;
    assign b       = in_ch.data_byte;
    assign p       = in_ch.first_byte ? '0 : pos_reg;
    assign magic_e = in_ch.first_byte ? '0 : magic_reg;
    assign name_e  = in_ch.first_byte ? '0 : name_reg;
    assign desc_e  = in_ch.first_byte ? '0 : desc_reg;
    assign size_e  = in_ch.first_byte ? '0 : size_reg;
    assign chk_e   = in_ch.first_byte ? '0 : chk_reg;
    assign xor_e   = in_ch.first_byte ? '0 : xor_reg;

    // byte lane of the size field: positions 7..10 map to lanes 0..3
    assign size_sel = p[1:0] + 2'd1;

    // field captures at fixed positions
    always_comb
    begin
        magic_next = magic_e;
        name_next  = name_e;
        desc_next  = desc_e;
        size_next  = size_e;
        chk_next   = chk_e;
        priority if (p < POS_W'(rhv_pkg::POS_MAGIC_LAST))
        begin
            magic_next[{p[1:0], 3'b000} +: 8] = b;
        end
        else if (p == POS_W'(rhv_pkg::POS_NAME_LEN))
        begin
            name_next = b;
        end
        else if (p == POS_W'(rhv_pkg::POS_DESC_LO))
        begin
            desc_next[7:0] = b;
        end
        else if (p == POS_W'(rhv_pkg::POS_DESC_HI))
        begin
            desc_next[15:8] = b;
        end
        else if (p >= POS_W'(rhv_pkg::POS_SIZE_FIRST) && p <= POS_W'(rhv_pkg::POS_SIZE_LAST))
        begin
            size_next[{size_sel, 3'b000} +: 8] = b;
        end
        else if (p == POS_W'(rhv_pkg::POS_CHECKSUM))
        begin
            chk_next = b;
        end
        else
        begin
            chk_next = chk_e;
        end
    end

    // running xor skips the checksum byte
    assign xor_next = (p == POS_W'(rhv_pkg::POS_CHECKSUM)) ? xor_e : (xor_e ^ b);

    // checks
    assign last_pos   = POS_W'(FIXED_LEN) + POS_W'(name_next) + POS_W'(desc_next) - POS_W'(1);
    assign bad_magic  = (p == POS_W'(rhv_pkg::POS_MAGIC_LAST))
                        && ({b, magic_e} != magic_word_reg);
    assign size_large = (p == POS_W'(rhv_pkg::POS_SIZE_LAST)) && (size_next > max_size_reg);
    assign hdr_end    = (p >= POS_W'(rhv_pkg::POS_CHECKSUM)) && (p == last_pos);
    assign res_now    = act && (bad_magic || size_large || hdr_end);

    // status of the result in hand
    always_comb
    begin
        priority if (bad_magic)
        begin
            res_status = rhv_pkg::ST_BAD_MAGIC;
        end
        else if (size_large)
        begin
            res_status = rhv_pkg::ST_SIZE_LARGE;
        end
        else if (xor_next == chk_next)
        begin
            res_status = rhv_pkg::ST_OK;
        end
        else
        begin
            res_status = rhv_pkg::ST_CHK_FAIL;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= '0;
            max_size_reg   <= rhv_pkg::SIZE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (rhv_pkg::rhv_cfg_idx_t'(cfg_index))
                rhv_pkg::CFG_MAGIC_WORD: magic_word_reg <= cfg_data;
                rhv_pkg::CFG_SIZE_LIMIT: max_size_reg   <= cfg_data;
                default:                 magic_word_reg <= magic_word_reg;
            endcase
        end
    end

    // header control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else if (accept && act)
        begin
            active_reg <= !res_now;
            pos_reg    <= p + POS_W'(1);
        end
    end

    // captured fields and running xor
    always_ff @(posedge clk)
    begin
        if (accept && act)
        begin
            magic_reg <= magic_next;
            name_reg  <= name_next;
            desc_reg  <= desc_next;
            size_reg  <= size_next;
            chk_reg   <= chk_next;
            xor_reg   <= xor_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && res_now)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload; bad magic reports no fields
    always_ff @(posedge clk)
    begin
        if (accept && res_now)
        begin
            status_reg   <= res_status;
            out_name_reg <= bad_magic ? '0 : name_next;
            out_desc_reg <= bad_magic ? '0 : desc_next;
            out_size_reg <= bad_magic ? '0 : size_next;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.status             = status_reg;
    assign out_ch.name_length        = out_name_reg;
    assign out_ch.description_length = out_desc_reg;
    assign out_ch.rom_size           = out_size_reg;

    // checks on the control logic
    `RHV_ASSERT(a_magic_no_fields, !(out_valid_reg && status_reg == rhv_pkg::ST_BAD_MAGIC) || (out_name_reg == '0 && out_desc_reg == '0 && out_size_reg == '0), "bad magic result carries fields")
    `RHV_ASSERT_NEXT(a_idle_after_result, accept && res_now, !active_reg && out_valid_reg, "header still active after its result")
    `RHV_ASSERT_NEXT(a_hold_on_stall, !in_ready, $stable(pos_reg) && $stable(active_reg), "header state moved while input was stalled")

endmodule

`default_nettype wire
